// ===== design/rmar_pkg.sv =====
// shared constants and types of the rate monotonic admit and rank core
package rmar_pkg;

  localparam int MaxTasks   = 8;
  localparam int IdxW       = $clog2(MaxTasks);
  localparam int CntW       = $clog2(MaxTasks + 1);
  localparam int PeriodW    = 16;
  localparam int DvdW       = 2 * PeriodW;
  localparam int UtilW      = 20;
  localparam int PrioW      = 4;
  localparam int OutIdxW    = 3;
  localparam int UtilSat    = 524288;
  localparam int LimitReset = 45875;
  localparam int DivBits    = 2;
  localparam int DivSteps   = DvdW / DivBits;
  localparam int DivCntW    = $clog2(DivSteps);

  typedef struct packed {
    logic               start;
    logic [PeriodW-1:0] num;
    logic [PeriodW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [UtilW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== design/rmar_if.sv =====
// request and result channel interfaces
interface rmar_in_if;
  import rmar_pkg::*;

  logic               valid;
  logic               ready;
  logic [PeriodW-1:0] task_period;
  logic [PeriodW-1:0] compute_time;
  logic               last_task;

  modport source (output valid, task_period, compute_time, last_task, input ready);
  modport sink (input valid, task_period, compute_time, last_task, output ready);
endinterface

interface rmar_out_if;
  import rmar_pkg::*;

  logic               valid;
  logic               ready;
  logic [OutIdxW-1:0] task_index;
  logic [PrioW-1:0]   priority_res;
  logic               admitted;
  logic [UtilW-1:0]   utilization;
  logic               overflowed;
  logic               last_result;

  modport source (output valid, task_index, priority_res, admitted, utilization, overflowed,
                  last_result, input ready);
  modport sink (input valid, task_index, priority_res, admitted, utilization, overflowed,
                last_result, output ready);
endinterface

// ===== design/rate_monotonic_admit_and_rank_core.sv =====
// top level: task set loading, admission check, rank sort and result sequencing
//
// The request channel loads one task per request (period, compute time,
// last flag). Each stored task with a nonzero period runs through a shared
// iterative divider for its Q16 utilization; a zero period or a dropped
// request does not use the divider.
// The request with the last flag starts evaluation. A rejected set (sum not
// below the limit, a zero period, or more than 8 loads) gives one result.
// An admitted set of n tasks is ranked by one comparator, one stored period
// per cycle from the period memory, and then gives n results in ascending
// period order, each held while the receiver stalls.
// The request channel is not ready while a division runs, nor from the last
// request of a set until the last result of its evaluation is taken. A
// stalled receiver holds the result register and the sequencer. The limit
// register may be written at any clock edge while the core is idle.
// Reset clears the task count, the flags, the sum and the channels and sets
// the limit to 0.7 in Q16; the period memory is not cleared.
module rate_monotonic_admit_and_rank_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rmar_in_if.sink                   req_i,
  rmar_out_if.source                res_o,
  input  logic                      cfg_we_i,
  input  logic [rmar_pkg::UtilW-1:0] cfg_wdata_i
);
  import rmar_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DIV    = 10'b0000000010,
    ST_CHK    = 10'b0000000100,
    ST_RD_I   = 10'b0000001000,
    ST_LD_I   = 10'b0000010000,
    ST_CMP    = 10'b0000100000,
    ST_E_RD   = 10'b0001000000,
    ST_E_LD   = 10'b0010000000,
    ST_E_WAIT = 10'b0100000000,
    ST_REJ    = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               zero_q, zero_d;
  logic [UtilW-1:0]   sum_q, sum_d;
  logic               last_q, last_d;
  logic [UtilW-1:0]   limit_q;
  logic [IdxW-1:0]    i_q, i_d;
  logic [IdxW-1:0]    j_q, j_d;
  logic [IdxW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    rank_q, rank_d;
  logic               dup_q, dup_d;
  logic [CntW-1:0]    lvl_q, lvl_d;
  logic [PeriodW-1:0] pi_q, pi_d;
  logic [PeriodW-1:0] prev_q, prev_d;
  logic               vld_q, vld_d;
  logic [OutIdxW-1:0] oidx_q, oidx_d;
  logic [PrioW-1:0]   opri_q, opri_d;
  logic               oadm_q, oadm_d;
  logic               oovf_q, oovf_d;
  logic               olast_q, olast_d;
  logic [IdxW-1:0]    order_q [MaxTasks];

  logic               req_acc;
  logic               res_acc;
  logic               ram_we;
  logic [IdxW-1:0]    ram_raddr;
  logic [PeriodW-1:0] ram_rdata;
  logic               ord_we;
  logic [IdxW-1:0]    ord_waddr;
  logic [IdxW-1:0]    last_idx;
  logic               has_room;
  logic               less_b;
  logic               dup_b;
  logic [IdxW-1:0]    rank_nx;
  logic [CntW-1:0]    pri_now;
  logic [UtilW:0]     sum_add;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign req_acc  = req_i.valid && req_i.ready;
  assign res_acc  = res_o.valid && res_o.ready;
  assign has_room = cnt_q < CntW'(MaxTasks);
  assign ram_we   = req_acc && has_room;
  assign last_idx = IdxW'(cnt_q - CntW'(1));

  assign div_req.start = req_acc && has_room && (req_i.task_period != '0);
  assign div_req.num   = req_i.compute_time;
  assign div_req.den   = req_i.task_period;

  assign less_b  = (ram_rdata < pi_q) || ((ram_rdata == pi_q) && (j_q < i_q));
  assign dup_b   = (ram_rdata == pi_q) && (j_q < i_q);
  assign rank_nx = rank_q + IdxW'(less_b);
  assign pri_now = ((k_q != '0) && (ram_rdata > prev_q)) ? lvl_q - CntW'(1) : lvl_q;
  assign sum_add = {1'b0, sum_q} + {1'b0, div_rsp.quot};

  rmar_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  rmar_ram #(
    .Width(PeriodW),
    .Depth(MaxTasks)
  ) u_period_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(req_i.task_period),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    unique case (state_q)
      ST_RD_I: ram_raddr = i_q;
      ST_CMP:  ram_raddr = j_q + IdxW'(1);
      ST_E_RD: ram_raddr = order_q[k_q];
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    zero_d   = zero_q;
    sum_d    = sum_q;
    last_d   = last_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    rank_d   = rank_q;
    dup_d    = dup_q;
    lvl_d    = lvl_q;
    pi_d     = pi_q;
    prev_d   = prev_q;
    vld_d    = vld_q;
    oidx_d   = oidx_q;
    opri_d   = opri_q;
    oadm_d   = oadm_q;
    oovf_d   = oovf_q;
    olast_d  = olast_q;
    ord_we   = 1'b0;
    ord_waddr = rank_nx;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          last_d = req_i.last_task;
          if (has_room) begin
            cnt_d = cnt_q + CntW'(1);
            if (req_i.task_period == '0) begin
              zero_d = 1'b1;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (div_req.start) begin
            state_d = ST_DIV;
          end else if (req_i.last_task) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          sum_d   = (sum_add > (UtilW + 1)'(UtilSat)) ? UtilW'(UtilSat) : sum_add[UtilW-1:0];
          state_d = last_q ? ST_CHK : ST_IDLE;
        end
      end
      ST_CHK: begin
        lvl_d = '0;
        i_d   = '0;
        if (ovf_q || zero_q || (sum_q >= limit_q)) begin
          vld_d   = 1'b1;
          oidx_d  = '0;
          opri_d  = '0;
          oadm_d  = 1'b0;
          oovf_d  = ovf_q;
          olast_d = 1'b1;
          state_d = ST_REJ;
        end else begin
          state_d = ST_RD_I;
        end
      end
      ST_RD_I: begin
        state_d = ST_LD_I;
      end
      ST_LD_I: begin
        pi_d    = ram_rdata;
        j_d     = '0;
        rank_d  = '0;
        dup_d   = 1'b0;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        rank_d = rank_nx;
        dup_d  = dup_q || dup_b;
        j_d    = j_q + IdxW'(1);
        if (j_q == last_idx) begin
          ord_we = 1'b1;
          if (!(dup_q || dup_b)) begin
            lvl_d = lvl_q + CntW'(1);
          end
          if (i_q == last_idx) begin
            k_d     = '0;
            state_d = ST_E_RD;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_RD_I;
          end
        end
      end
      ST_E_RD: begin
        state_d = ST_E_LD;
      end
      ST_E_LD: begin
        lvl_d   = pri_now;
        prev_d  = ram_rdata;
        vld_d   = 1'b1;
        oidx_d  = OutIdxW'(order_q[k_q]);
        opri_d  = PrioW'(pri_now);
        oadm_d  = 1'b1;
        oovf_d  = 1'b0;
        olast_d = (k_q == last_idx);
        state_d = ST_E_WAIT;
      end
      ST_E_WAIT, ST_REJ: begin
        if (res_acc) begin
          vld_d = 1'b0;
          if ((state_q == ST_REJ) || (k_q == last_idx)) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            zero_d  = 1'b0;
            sum_d   = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + IdxW'(1);
            state_d = ST_E_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      zero_q  <= 1'b0;
      sum_q   <= '0;
      last_q  <= 1'b0;
      limit_q <= UtilW'(LimitReset);
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rank_q  <= '0;
      dup_q   <= 1'b0;
      lvl_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      zero_q  <= zero_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rank_q  <= rank_d;
      dup_q   <= dup_d;
      lvl_q   <= lvl_d;
      vld_q   <= vld_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q    <= pi_d;
    prev_q  <= prev_d;
    oidx_q  <= oidx_d;
    opri_q  <= opri_d;
    oadm_q  <= oadm_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
    if (ord_we) begin
      order_q[ord_waddr] <= i_q;
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = vld_q;
  assign res_o.task_index   = oidx_q;
  assign res_o.priority_res = opri_q;
  assign res_o.admitted     = oadm_q;
  assign res_o.utilization  = sum_q;
  assign res_o.overflowed   = oovf_q;
  assign res_o.last_result  = olast_q;

`ifndef NO_ASSERTIONS
  a_valid_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (state_q == ST_E_WAIT || state_q == ST_REJ))
    else $error("result valid outside an output state");

  a_ready_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !res_o.valid)
    else $error("request taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTasks))
    else $error("task count beyond capacity");

  a_admitted_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.admitted) |-> (!res_o.overflowed && res_o.priority_res != '0))
    else $error("admitted result with bad priority or overflow");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division state");
`endif

endmodule

// ===== design/rmar_ram.sv =====
// generic single write port ram with registered read
module rmar_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/rmar_div.sv =====
// iterative restoring divider, two quotient bits per cycle, saturated q16 result
module rmar_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmar_pkg::div_req_t  req_i,
  output rmar_pkg::div_rsp_t  rsp_o
);
  import rmar_pkg::*;

  logic [PeriodW-1:0] rem_q, rem_d;
  logic [DvdW-1:0]    dq_q, dq_d;
  logic [PeriodW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [PeriodW:0]   trial;

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    trial = '0;
    for (int b = 0; b < DivBits; b++) begin
      trial = {rem_d, dq_d[DvdW-1]};
      dq_d  = {dq_d[DvdW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        dq_d[0] = 1'b1;
      end
      rem_d = trial[PeriodW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dq_q  <= {req_i.num, PeriodW'(0)};
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = (dq_q > DvdW'(UtilSat)) ? UtilW'(UtilSat) : dq_q[UtilW-1:0];

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the rate monotonic admit and rank core
module tb_top;
  import rmar_pkg::*;

  typedef struct packed {
    logic [OutIdxW-1:0] task_index;
    logic [PrioW-1:0]   priority_res;
    logic               admitted;
    logic [UtilW-1:0]   utilization;
    logic               overflowed;
    logic               last_result;
  } rank_res_t;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] compute;
    logic               last;
    logic               typed;
    rank_res_t          want;
  } dir_row_t;

  localparam int DirRowCnt = 22;

  localparam dir_row_t DirRows [DirRowCnt] = '{
    '{16'd0,     16'd0,     1'b1, 1'b1, '{3'd0, 4'd0, 1'b0, 20'd0,      1'b0, 1'b1}},
    '{16'd65535, 16'd0,     1'b1, 1'b1, '{3'd0, 4'd1, 1'b1, 20'd0,      1'b0, 1'b1}},
    '{16'd1,     16'd65535, 1'b1, 1'b1, '{3'd0, 4'd0, 1'b0, 20'd524288, 1'b0, 1'b1}},
    '{16'd65535, 16'd65535, 1'b1, 1'b1, '{3'd0, 4'd0, 1'b0, 20'd65536,  1'b0, 1'b1}},
    // zero period inside a set
    '{16'd20,    16'd1,     1'b0, 1'b0, '0},
    '{16'd0,     16'd0,     1'b0, 1'b0, '0},
    '{16'd30,    16'd1,     1'b1, 1'b0, '0},
    // one request beyond capacity
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b0, 1'b0, '0},
    '{16'd1,     16'd0,     1'b1, 1'b1, '{3'd0, 4'd0, 1'b0, 20'd0,      1'b1, 1'b1}},
    // tied periods keep load order
    '{16'd300,   16'd3,     1'b0, 1'b0, '0},
    '{16'd100,   16'd2,     1'b0, 1'b0, '0},
    '{16'd300,   16'd4,     1'b0, 1'b0, '0},
    '{16'd200,   16'd1,     1'b0, 1'b0, '0},
    '{16'd100,   16'd5,     1'b0, 1'b0, '0},
    '{16'd50,    16'd6,     1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [UtilW-1:0] cfg_wdata;

  rmar_in_if  req_if ();
  rmar_out_if res_if ();

  rate_monotonic_admit_and_rank_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [UtilW-1:0]   util_limit;
  logic [PeriodW-1:0] period_mem [MaxTasks];
  logic [PeriodW-1:0] compute_mem [MaxTasks];
  int                 loaded;
  bit                 dropped;

  rank_res_t expected_ranks [$];

  int errors;
  int results_checked;
  int requests_sent;
  int sets_done;
  int sets_admitted;
  int limit_writes;
  int snd_idle;
  int rcv_idle;

  function automatic int unsigned util_quotient(logic [PeriodW-1:0] c, logic [PeriodW-1:0] p);
    logic [DvdW-1:0] q;
    if (p == '0) return 0;
    q = {c, 16'h0000} / {16'h0000, p};
    return (q > UtilSat) ? UtilSat : q;
  endfunction

  task automatic rank_and_admit(input logic [PeriodW-1:0] p, input logic [PeriodW-1:0] c,
                                input logic last, output int n, output rank_res_t res [MaxTasks]);
    int unsigned sum;
    int          lvl;
    int          order [MaxTasks];
    int          i;
    int          j;
    int          v;
    bit          zero_p;
    bit          ok;
    n = 0;
    if (loaded < MaxTasks) begin
      period_mem[loaded] = p;
      compute_mem[loaded] = c;
      loaded++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    sum = 0;
    zero_p = 1'b0;
    for (i = 0; i < loaded; i++) begin
      if (period_mem[i] == '0) zero_p = 1'b1;
      sum += util_quotient(compute_mem[i], period_mem[i]);
      if (sum > UtilSat) sum = UtilSat;
    end
    ok = !dropped && !zero_p && (sum < util_limit);
    sets_done++;
    if (!ok) begin
      res[0] = '{3'd0, 4'd0, 1'b0, sum[UtilW-1:0], dropped, 1'b1};
      n = 1;
    end else begin
      sets_admitted++;
      n = loaded;
      for (i = 0; i < n; i++) begin
        v = i;
        j = i;
        while (j > 0 && period_mem[order[j-1]] > period_mem[v]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      lvl = 1;
      for (i = n - 1; i >= 0; i--) begin
        res[i] = '{order[i][OutIdxW-1:0], lvl[PrioW-1:0], 1'b1, sum[UtilW-1:0], 1'b0,
                   (i == n - 1)};
        if (i > 0 && period_mem[order[i]] > period_mem[order[i-1]]) lvl++;
      end
    end
    loaded = 0;
    dropped = 1'b0;
  endtask

  task automatic send_request(input logic [PeriodW-1:0] p, input logic [PeriodW-1:0] c,
                              input logic last, input logic typed, input rank_res_t want);
    rank_res_t res [MaxTasks];
    int        n;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.task_period = p;
    req_if.compute_time = c;
    req_if.last_task = last;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    rank_and_admit(p, c, last, n, res);
    if (typed) begin
      expected_ranks.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) expected_ranks.push_back(res[k]);
    end
  endtask

  task automatic send_random_set();
    int                 kind;
    int                 n;
    int                 zpos;
    logic [PeriodW-1:0] p;
    logic [PeriodW-1:0] c;
    logic [PeriodW-1:0] prev_p;
    kind = $urandom_range(0, 99);
    if (kind < 90) n = $urandom_range(1, MaxTasks);
    else n = $urandom_range(MaxTasks + 1, MaxTasks + 3);
    if (kind >= 80 && kind < 90 && n < 2) n = 2;
    zpos = $urandom_range(0, n - 1);
    prev_p = PeriodW'($urandom_range(1, 65535));
    for (int k = 0; k < n; k++) begin
      if (kind >= 65 && kind < 80) begin
        p = PeriodW'($urandom_range(0, 65535));
        c = PeriodW'($urandom_range(0, 65535));
      end else begin
        p = (k > 0 && $urandom_range(0, 3) == 0) ? prev_p : PeriodW'($urandom_range(1, 65535));
        c = PeriodW'($urandom_range(0, p / (2 * n)));
        prev_p = p;
        if (kind >= 80 && kind < 90 && k == zpos) p = '0;
      end
      send_request(p, c, (k == n - 1), 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(input logic [UtilW-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    util_limit = v;
    limit_writes++;
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin : result_check
    rank_res_t got;
    rank_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.task_index, res_if.priority_res, res_if.admitted, res_if.utilization,
              res_if.overflowed, res_if.last_result};
      results_checked++;
      if (expected_ranks.size() == 0) begin
        if (errors < 10)
          $display("unexpected result idx %0d pri %0d adm %0b util %0d ovf %0b last %0b",
                   got.task_index, got.priority_res, got.admitted, got.utilization,
                   got.overflowed, got.last_result);
        errors++;
      end else begin
        want = expected_ranks.pop_front();
        if (got.task_index !== want.task_index || got.priority_res !== want.priority_res ||
            got.admitted !== want.admitted || got.utilization !== want.utilization ||
            got.overflowed !== want.overflowed || got.last_result !== want.last_result) begin
          if (errors < 10) begin
            $display("mismatch exp idx %0d pri %0d adm %0b util %0d ovf %0b last %0b",
                     want.task_index, want.priority_res, want.admitted, want.utilization,
                     want.overflowed, want.last_result);
            $display("         got idx %0d pri %0d adm %0b util %0d ovf %0b last %0b",
                     got.task_index, got.priority_res, got.admitted, got.utilization,
                     got.overflowed, got.last_result);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          start;
    int          budget;
    logic [UtilW-1:0] lim;
    req_if.valid = 1'b0;
    req_if.task_period = '0;
    req_if.compute_time = '0;
    req_if.last_task = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    util_limit = UtilW'(LimitReset);
    loaded = 0;
    dropped = 1'b0;
    errors = 0;
    results_checked = 0;
    requests_sent = 0;
    sets_done = 0;
    sets_admitted = 0;
    limit_writes = 0;
    snd_idle = 22;
    rcv_idle = 83;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DirRowCnt; r++)
      send_request(DirRows[r].period, DirRows[r].compute, DirRows[r].last, DirRows[r].typed,
                   DirRows[r].want);

    for (int seg = 0; seg < 4; seg++) begin
      drain_results();
      @(negedge clk);
      req_if.valid = 1'b0;
      case (seg)
        0: begin
          snd_idle = 22; rcv_idle = 83; lim = UtilW'(UtilSat); budget = 110;
        end
        1: begin
          snd_idle = 83; rcv_idle = 22; lim = '0; budget = 40;
        end
        2: begin
          snd_idle = 83; rcv_idle = 22; lim = UtilW'($urandom_range(1, UtilSat - 1));
          budget = 90;
        end
        default: begin
          snd_idle = 0; rcv_idle = 0; lim = UtilW'(LimitReset); budget = 120;
        end
      endcase
      write_limit(lim);
      start = requests_sent;
      while (requests_sent - start < budget) send_random_set();
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    drain_results();
    $display("%0d requests in %0d task sets (%0d admitted), %0d results checked",
             requests_sent, sets_done, sets_admitted, results_checked);
    $display("%0d limit settings, extremes included, under three idle patterns",
             limit_writes);
    if (errors == 0 && expected_ranks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rmar_pkg.sv
design/rmar_if.sv
design/rmar_ram.sv
design/rmar_div.sv
design/rate_monotonic_admit_and_rank_core.sv
verif/tb_top.sv
